// ===== hw/rtl/box_circle_contact_core_assert.svh =====
// Assertion macros shared by the contact core RTL.
// Each macro wraps one concurrent assertion clocked on clk and
// disabled while rst_n is low.
`ifndef BOX_CIRCLE_CONTACT_CORE_ASSERT_SVH
`define BOX_CIRCLE_CONTACT_CORE_ASSERT_SVH

// A condition that must hold at every clock edge.
`define BCC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define BCC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define BCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/bcc_pkg.sv =====
// ----------------------------------------------------------------------------
// bcc_pkg
// Types and constants shared by the box and circle contact pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bcc_pkg;

    // Number of two-bit steps of the square root (34-bit radicand).
    localparam int SQRT_STEPS = 17;
    // Number of quotient bits of the direction divide.
    localparam int DIV_STEPS  = 15;

    // One input item: a box and a circle.
    typedef struct packed {
        logic signed [15:0] box_left;
        logic signed [15:0] box_top;
        logic signed [15:0] box_right;
        logic signed [15:0] box_bottom;
        logic signed [15:0] circ_x;
        logic signed [15:0] circ_y;
        logic        [14:0] circ_r;
    } shape_t;

    // One result item.
    typedef struct packed {
        logic               hit;
        logic        [15:0] depth;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
    } contact_t;

    // Per-item data that rides along with the square root.
    typedef struct packed {
        logic        hit;
        logic        in_box;
        logic [14:0] r;
        logic        neg_x;
        logic        neg_y;
        logic [15:0] ax;
        logic [15:0] ay;
    } sqrt_side_t;

    // Per-item data that rides along with the divide.
    typedef struct packed {
        logic        hit;
        logic        dir_ok;
        logic        neg_x;
        logic        neg_y;
        logic [15:0] depth;
        logic [16:0] len;
    } div_side_t;

endpackage

// ===== hw/rtl/bcc_front.sv =====
// ----------------------------------------------------------------------------
// bcc_front
// Nearest point, offsets, squared length and hit test in three stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcc_front
    import bcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        valid,
    input  shape_t      shape,
    output logic        rad_valid,
    output logic [33:0] rad,
    output sqrt_side_t  side
);

    function automatic logic [15:0] abs17(input logic signed [16:0] v);
        logic signed [16:0] n;
        begin
            n = -v;
            abs17 = v[16] ? n[15:0] : v[15:0];
        end
    endfunction

    function automatic logic signed [16:0] clamp17(input logic signed [16:0] c,
                                                   input logic signed [16:0] lo,
                                                   input logic signed [16:0] hi);
        begin
            if (c <= lo)
                clamp17 = lo;
            else if (c >= hi)
                clamp17 = hi;
            else
                clamp17 = c;
        end
    endfunction

    logic signed [16:0] left, top, right, bottom, cx, cy;
    logic signed [16:0] nx, ny;
    logic signed [16:0] dx_next, dy_next;
    logic               inside_next;

    assign left   = {shape.box_left[15], shape.box_left};
    assign top    = {shape.box_top[15], shape.box_top};
    assign right  = {shape.box_right[15], shape.box_right};
    assign bottom = {shape.box_bottom[15], shape.box_bottom};
    assign cx     = {shape.circ_x[15], shape.circ_x};
    assign cy     = {shape.circ_y[15], shape.circ_y};

    // Nearest box point; a centre between left and right snaps to the nearer
    // of the top and bottom edges.
    always_comb
    begin
        if (cx <= left)
        begin
            nx = left;
            ny = clamp17(cy, top, bottom);
        end
        else if (cx >= right)
        begin
            nx = right;
            ny = clamp17(cy, top, bottom);
        end
        else
        begin
            nx = cx;
            ny = (abs17(cy - top) < abs17(cy - bottom)) ? top : bottom;
        end
        dx_next     = nx - cx;
        dy_next     = ny - cy;
        inside_next = (cx > left) && (cx < right) && (cy > top) && (cy < bottom);
    end

    // Stage 1: offsets.
    logic               v1_reg;
    logic signed [16:0] dx_reg, dy_reg;
    logic               inside1_reg;
    logic [14:0]        r1_reg;

    // Stage 2: magnitudes and squares.
    logic        v2_reg;
    logic [15:0] ax_reg, ay_reg;
    logic        negx_reg, negy_reg;
    logic [31:0] sqx_reg, sqy_reg;
    logic [29:0] rr_reg;
    logic        inside2_reg;
    logic [14:0] r2_reg;

    // Stage 3: squared length and hit.
    logic        v3_reg;
    logic [32:0] s_reg;
    sqrt_side_t  side_reg;

    logic [15:0] ax_next, ay_next;
    logic [32:0] s_next;

    assign ax_next = abs17(dx_reg);
    assign ay_next = abs17(dy_reg);
    assign s_next  = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg      <= dx_next;
            dy_reg      <= dy_next;
            inside1_reg <= inside_next;
            r1_reg      <= shape.circ_r;

            ax_reg      <= ax_next;
            ay_reg      <= ay_next;
            negx_reg    <= dx_reg[16];
            negy_reg    <= dy_reg[16];
            sqx_reg     <= ax_next * ax_next;
            sqy_reg     <= ay_next * ay_next;
            rr_reg      <= r1_reg * r1_reg;
            inside2_reg <= inside1_reg;
            r2_reg      <= r1_reg;

            s_reg           <= s_next;
            side_reg.hit    <= inside2_reg || (s_next < {3'b000, rr_reg});
            side_reg.in_box <= inside2_reg;
            side_reg.r      <= r2_reg;
            side_reg.neg_x  <= negx_reg;
            side_reg.neg_y  <= negy_reg;
            side_reg.ax     <= ax_reg;
            side_reg.ay     <= ay_reg;
        end
    end

    assign rad_valid = v3_reg;
    assign rad       = {1'b0, s_reg};
    assign side      = side_reg;

endmodule

// ===== hw/rtl/bcc_sqrt.sv =====
// ----------------------------------------------------------------------------
// bcc_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcc_sqrt
    import bcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        valid,
    input  logic [33:0] rad,
    input  sqrt_side_t  side_in,
    output logic        len_valid,
    output logic [16:0] len,
    output sqrt_side_t  side_out
);

    logic [SQRT_STEPS-1:0] vld_reg;
    logic [33:0]           rad_reg  [SQRT_STEPS];
    logic [17:0]           rem_reg  [SQRT_STEPS];
    logic [16:0]           root_reg [SQRT_STEPS];
    sqrt_side_t            side_reg [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_step
        logic        vld_prev;
        logic [33:0] rad_prev;
        logic [17:0] rem_prev;
        logic [16:0] root_prev;
        sqrt_side_t  side_prev;
        logic [19:0] rem_sh, trial;
        logic        ge;

        if (k == 0)
        begin : g_first
            assign vld_prev  = valid;
            assign rad_prev  = rad;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign side_prev = side_in;
        end
        else
        begin : g_rest
            assign vld_prev  = vld_reg[k-1];
            assign rad_prev  = rad_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        // Bring down the next two radicand bits and try the new root bit.
        assign rem_sh = {rem_prev, rad_prev[33:32]};
        assign trial  = {1'b0, root_prev, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k]  <= {rad_prev[31:0], 2'b00};
                rem_reg[k]  <= ge ? 18'(rem_sh - trial) : rem_sh[17:0];
                root_reg[k] <= {root_prev[15:0], ge};
                side_reg[k] <= side_prev;
            end
        end
    end

    assign len_valid = vld_reg[SQRT_STEPS-1];
    assign len       = root_reg[SQRT_STEPS-1];
    assign side_out  = side_reg[SQRT_STEPS-1];

endmodule

// ===== hw/rtl/bcc_div.sv =====
// ----------------------------------------------------------------------------
// bcc_div
// Depth and rounded direction magnitudes; restoring divide, one bit a stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcc_div
    import bcc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 valid,
    input  logic [16:0]          len,
    input  sqrt_side_t           side_in,
    output logic                 q_valid,
    output logic [DIV_STEPS-1:0] qx,
    output logic [DIV_STEPS-1:0] qy,
    output div_side_t            side_out
);

    // Setup stage: depth and numerators |d| * 2^14 + len / 2.
    logic        va_reg;
    logic [30:0] numx_reg, numy_reg;
    div_side_t   sa_reg;

    logic [17:0] sum_in;
    logic [16:0] diff_in;
    logic [15:0] depth_next;

    assign sum_in  = {3'b000, side_in.r} + {1'b0, len};
    assign diff_in = {2'b00, side_in.r} - len;

    always_comb
    begin
        if (side_in.in_box)
            depth_next = (sum_in > 18'd65535) ? 16'hFFFF : sum_in[15:0];
        else if (side_in.hit)
            depth_next = diff_in[15:0];
        else
            depth_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else if (en)
            va_reg <= valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            numx_reg      <= {1'b0, side_in.ax, 14'd0} + {15'd0, len[16:1]};
            numy_reg      <= {1'b0, side_in.ay, 14'd0} + {15'd0, len[16:1]};
            sa_reg.hit    <= side_in.hit;
            sa_reg.dir_ok <= side_in.hit && (len != '0);
            sa_reg.neg_x  <= side_in.neg_x;
            sa_reg.neg_y  <= side_in.neg_y;
            sa_reg.depth  <= depth_next;
            sa_reg.len    <= len;
        end
    end

    // Divide stages.
    logic [DIV_STEPS-1:0] vld_reg;
    logic [16:0]          remx_reg [DIV_STEPS];
    logic [16:0]          remy_reg [DIV_STEPS];
    logic [14:0]          lowx_reg [DIV_STEPS];
    logic [14:0]          lowy_reg [DIV_STEPS];
    logic [14:0]          qx_reg   [DIV_STEPS];
    logic [14:0]          qy_reg   [DIV_STEPS];
    div_side_t            ds_reg   [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_step
        logic        vld_prev;
        logic [16:0] remx_prev, remy_prev;
        logic [14:0] lowx_prev, lowy_prev, qx_prev, qy_prev;
        div_side_t   ds_prev;
        logic [17:0] shx, shy, lenx;
        logic        gex, gey;

        if (j == 0)
        begin : g_first
            assign vld_prev  = va_reg;
            assign remx_prev = {1'b0, numx_reg[30:15]};
            assign remy_prev = {1'b0, numy_reg[30:15]};
            assign lowx_prev = numx_reg[14:0];
            assign lowy_prev = numy_reg[14:0];
            assign qx_prev   = '0;
            assign qy_prev   = '0;
            assign ds_prev   = sa_reg;
        end
        else
        begin : g_rest
            assign vld_prev  = vld_reg[j-1];
            assign remx_prev = remx_reg[j-1];
            assign remy_prev = remy_reg[j-1];
            assign lowx_prev = lowx_reg[j-1];
            assign lowy_prev = lowy_reg[j-1];
            assign qx_prev   = qx_reg[j-1];
            assign qy_prev   = qy_reg[j-1];
            assign ds_prev   = ds_reg[j-1];
        end

        // Shift in the next numerator bit and subtract the length if it fits.
        assign shx  = {remx_prev, lowx_prev[14]};
        assign shy  = {remy_prev, lowy_prev[14]};
        assign lenx = {1'b0, ds_prev.len};
        assign gex  = shx >= lenx;
        assign gey  = shy >= lenx;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j] <= 1'b0;
            else if (en)
                vld_reg[j] <= vld_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                remx_reg[j] <= gex ? 17'(shx - lenx) : shx[16:0];
                remy_reg[j] <= gey ? 17'(shy - lenx) : shy[16:0];
                lowx_reg[j] <= {lowx_prev[13:0], 1'b0};
                lowy_reg[j] <= {lowy_prev[13:0], 1'b0};
                qx_reg[j]   <= {qx_prev[13:0], gex};
                qy_reg[j]   <= {qy_prev[13:0], gey};
                ds_reg[j]   <= ds_prev;
            end
        end
    end

    assign q_valid  = vld_reg[DIV_STEPS-1];
    assign qx       = qx_reg[DIV_STEPS-1];
    assign qy       = qy_reg[DIV_STEPS-1];
    assign side_out = ds_reg[DIV_STEPS-1];

endmodule

// ===== hw/rtl/box_circle_contact_core.sv =====
// ----------------------------------------------------------------------------
// box_circle_contact_core
// Box against circle contact test: hit, penetration depth and unit direction.
// ----------------------------------------------------------------------------
// Usage:
//   An item on the shape channel (shape_valid, shape_stall, shape) carries one
//   box and one circle in Q12.4. It is taken at a clock edge with shape_valid
//   high and shape_stall low. Every item gives exactly one item on the
//   contact channel (contact_valid, contact_stall, contact), in input order.
//   From acceptance to contact_valid an item passes through the front stages
//   (nearest point and squared length), the square root stages (one root bit
//   per stage), the depth and divide setup stage, the direction divide stages
//   (one quotient bit per stage) and the output register. Throughput is one
//   item per cycle unless the output stalls; every stage holds its own item.
//   When contact_valid is high and contact_stall is high the whole pipeline
//   freezes and shape_stall rises in the same cycle; nothing is lost or
//   repeated, and bubbles in the pipeline keep flowing out otherwise.
//   Reset (rst_n low, asynchronous) clears all valid bits; no items are
//   in flight afterwards and the block takes items in the next cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module box_circle_contact_core
    import bcc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     shape_valid,
    output logic     shape_stall,
    input  shape_t   shape,
    output logic     contact_valid,
    input  logic     contact_stall,
    output contact_t contact
);

    `include "box_circle_contact_core_assert.svh"

    logic en;

    // The pipeline moves unless a finished item is held at the output.
    assign en          = !(contact_valid && contact_stall);
    assign shape_stall = !en;

    logic                 rad_valid;
    logic [33:0]          rad;
    sqrt_side_t           fside;
    logic                 len_valid;
    logic [16:0]          len;
    sqrt_side_t           sside;
    logic                 q_valid;
    logic [DIV_STEPS-1:0] qx, qy;
    div_side_t            dside;

    bcc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid     (shape_valid),
        .shape     (shape),
        .rad_valid (rad_valid),
        .rad       (rad),
        .side      (fside)
    );

    bcc_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid     (rad_valid),
        .rad       (rad),
        .side_in   (fside),
        .len_valid (len_valid),
        .len       (len),
        .side_out  (sside)
    );

    bcc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .valid    (len_valid),
        .len      (len),
        .side_in  (sside),
        .q_valid  (q_valid),
        .qx       (qx),
        .qy       (qy),
        .side_out (dside)
    );

    // Output stage: apply signs and clear fields of a miss.
    logic        out_valid_reg;
    contact_t    out_reg;
    logic [15:0] magx, magy;
    contact_t    out_next;

    assign magx = {1'b0, qx};
    assign magy = {1'b0, qy};

    always_comb
    begin
        out_next.hit   = dside.hit;
        out_next.depth = dside.hit ? dside.depth : 16'd0;
        if (dside.dir_ok)
        begin
            out_next.dir_x = dside.neg_x ? -magx : magx;
            out_next.dir_y = dside.neg_y ? -magy : magy;
        end
        else
        begin
            out_next.dir_x = '0;
            out_next.dir_y = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= q_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

    assign contact_valid = out_valid_reg;
    assign contact       = out_reg;

    // Checks on the result and the stall path.
    `BCC_ASSERT_IMP(a_miss_is_clear, contact_valid && !contact.hit, contact.depth == 16'd0 && contact.dir_x == 16'sd0 && contact.dir_y == 16'sd0, "miss with nonzero fields")
    `BCC_ASSERT_IMP(a_hit_has_depth, contact_valid && contact.hit, contact.depth != 16'd0, "hit with zero depth")
    `BCC_ASSERT_IMP(a_dir_range, contact_valid, contact.dir_x <= 16'sd16384 && contact.dir_x >= -16'sd16384 && contact.dir_y <= 16'sd16384 && contact.dir_y >= -16'sd16384, "direction out of range")
    `BCC_ASSERT_ALWAYS(a_stall_path, shape_stall == (contact_valid && contact_stall), "input stall mismatch")
    `BCC_ASSERT_NEXT(a_tail_held, contact_valid && contact_stall && q_valid, q_valid, "tail item lost while stalled")

endmodule
